// ===== design/bir_pkg.sv =====
// shared types and constants for the bilinear image resize unit
// no dependencies

package bir_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 13;
	localparam int unsigned SampleW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_IN_HEIGHT  = 3'd0,
		REG_IN_WIDTH   = 3'd1,
		REG_OUT_HEIGHT = 3'd2,
		REG_OUT_WIDTH  = 3'd3,
		REG_CHANNELS   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_TAP,
		ST_ACC,
		ST_ROUND,
		ST_OUT
	} state_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

endpackage

// ===== design/bilinear_image_resize_unit.sv =====
// bilinear image resize with asymmetric coordinates, one image store in a synchronous ram
// depends on bir_pkg
// load: one per cycle while idle and no register is being written. emit: after acceptance, the
// address steps (row and column position multiplies, the row offsets and their channel scaling),
// the tap steps through the single ram read port and a rounding step, then the result is presented;
// next transaction accepted the cycle after the result is taken.
// register write: serial scale division, one axis after the other, input stalled meanwhile;
// a further write restarts it. reset: registers 1, positions 0, same division;
// store contents undefined until loaded, no clearing pass.
module bilinear_image_resize_unit #(
	parameter int unsigned STORE_DEPTH  = 65536,
	parameter int unsigned MAX_DIM      = 4096,
	parameter int unsigned MAX_CHANNELS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bir_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bir_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic signed [15:0]           sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [15:0]           value,
	output logic                         last
);
	import bir_pkg::*;

	localparam int unsigned AW  = $clog2(STORE_DEPTH);
	localparam int unsigned PW  = $clog2(STORE_DEPTH + 1);
	localparam int unsigned DW  = $clog2(MAX_DIM + 1);
	localparam int unsigned CW  = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned SW  = DW + 16;
	localparam int unsigned QW  = DW + 16 + 1;
	localparam int unsigned LW  = 2 * DW + CW + 2;

	// store
	logic signed [15:0] mem [STORE_DEPTH];
	logic [AW-1:0]      rd_addr;
	logic signed [15:0] rd_data_q;
	logic               wr_en;

	// raw registers and effective values
	logic [12:0] raw_q [5];
	logic [DW-1:0] ih, iw, oh, ow;
	logic [CW-1:0] nc;

	function automatic logic [DW-1:0] clamp_dim(input logic [12:0] v);
		logic [DW-1:0] r;
		if (v == 13'd0) r = DW'(1);
		else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
		else r = DW'(v);
		return r;
	endfunction

	always_comb begin
		ih = clamp_dim(raw_q[0]);
		iw = clamp_dim(raw_q[1]);
		oh = clamp_dim(raw_q[2]);
		ow = clamp_dim(raw_q[3]);
		if (raw_q[4][8:0] == 9'd0) nc = CW'(1);
		else if (32'(raw_q[4][8:0]) > MAX_CHANNELS) nc = CW'(MAX_CHANNELS);
		else nc = CW'(raw_q[4][8:0]);
	end

	state_t state_q, state_d;

	logic [PW-1:0] load_pos_q;
	logic [DW-1:0] orow_q, ocol_q;
	logic [CW-1:0] och_q;
	logic [SW-1:0] rscale_q, cscale_q;

	// serial divider, one bit per cycle, both axes share it
	logic          div_axis_q;
	logic [5:0]    div_cnt_q;
	logic [QW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [SW-1:0] dividend;
	logic [DW-1:0] divisor;
	logic [QW-1:0] rem_sh;
	logic          div_bit;

	always_comb begin
		dividend = div_axis_q ? (SW'(iw) << 16) : (SW'(ih) << 16);
		divisor  = div_axis_q ? ow : oh;
		rem_sh   = {rem_q[QW-2:0], dividend[SW-1-div_cnt_q[4:0]]};
		div_bit  = rem_sh >= QW'(divisor);
	end

	// emit sequencer
	logic [2:0]     step_q;
	logic [SW+DW-1:0] prod_q;
	logic [DW-1:0]  y0_q, y1_q, x0_q, x1_q;
	logic [15:0]    fy_q, fx_q;
	logic [LW-1:0]  rowoff_q [2];
	logic [LW-1:0]  addr_q;
	logic           oob_s1;
	logic [16:0]    wy, wx;
	logic [33:0]    wt_q;
	logic signed [50:0] term_q;
	logic signed [51:0] acc_q;
	logic signed [15:0] val_q;
	logic           last_q;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || cfg_we;
	assign out_valid = (state_q == ST_OUT);
	assign value = val_q;
	assign last = last_q;

	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = ST_DIV;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_acc && opcode == OP_EMIT) state_d = ST_ADDR;
				ST_DIV:   if (div_axis_q && div_cnt_q == 6'(SW - 1)) state_d = ST_IDLE;
				ST_ADDR:  if (step_q == 3'd5) state_d = ST_TAP;
				ST_TAP:   if (step_q == 3'd5) state_d = ST_ROUND;
				ST_ACC:   state_d = ST_TAP;
				ST_ROUND: state_d = ST_OUT;
				ST_OUT:   if (out_acc) state_d = ST_IDLE;
				default:  state_d = ST_IDLE;
			endcase
		end
	end

	logic last_now;
	assign last_now = (32'(orow_q) + 1 >= 32'(oh)) && (32'(ocol_q) + 1 >= 32'(ow))
		&& (32'(och_q) + 1 >= 32'(nc));

	assign wr_en = in_acc && opcode == OP_LOAD && 32'(load_pos_q) < STORE_DEPTH;

	// tap index: step 0..3 selects (y0|y1) x (x0|x1)
	logic [1:0] tap_sel;
	assign tap_sel = step_q[1:0];
	assign wy = tap_sel[1] ? {1'b0, fy_q} : (17'h10000 - {1'b0, fy_q});
	assign wx = tap_sel[0] ? {1'b0, fx_q} : (17'h10000 - {1'b0, fx_q});

	always_comb begin
		addr_q = rowoff_q[tap_sel[1]];
	end

	logic [LW-1:0] tap_addr;
	assign tap_addr = addr_q + LW'((tap_sel[0] ? x1_q : x0_q) * nc) + LW'(och_q);
	assign rd_addr = tap_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[load_pos_q[AW-1:0]] <= sample;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DIV;
			for (int i = 0; i < 5; i++) raw_q[i] <= 13'd1;
			load_pos_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			och_q <= '0;
			div_axis_q <= 1'b0;
			div_cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			rscale_q <= '0;
			cscale_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) load_pos_q <= load_pos_q + PW'(1);
			// a write restarts the positions and both scale divisions
			if (cfg_we) begin
				if (cfg_index <= REG_CHANNELS) raw_q[cfg_index] <= cfg_data;
				load_pos_q <= '0;
				orow_q <= '0;
				ocol_q <= '0;
				och_q <= '0;
				div_axis_q <= 1'b0;
				div_cnt_q <= '0;
				rem_q <= '0;
			end else if (state_q == ST_DIV) begin
				quo_q <= {quo_q[SW-2:0], div_bit};
				if (div_cnt_q == 6'(SW - 1)) begin
					div_cnt_q <= '0;
					rem_q <= '0;
					div_axis_q <= 1'b1;
					if (!div_axis_q)
						rscale_q <= {quo_q[SW-2:0], div_bit};
					else
						cscale_q <= {quo_q[SW-2:0], div_bit};
				end else begin
					div_cnt_q <= div_cnt_q + 6'd1;
					rem_q <= div_bit ? rem_sh - QW'(divisor) : rem_sh;
				end
			end
			if (state_q == ST_IDLE && in_acc && opcode == OP_EMIT) step_q <= '0;
			if (state_q == ST_ADDR) step_q <= (step_q == 3'd5) ? 3'd0 : step_q + 3'd1;
			if (state_q == ST_TAP) step_q <= step_q + 3'd1;
			if (state_q == ST_ACC) step_q <= step_q;
			if (state_q == ST_OUT && out_acc && last_q) begin
				orow_q <= '0;
				ocol_q <= '0;
				och_q <= '0;
				load_pos_q <= '0;
			end else if (state_q == ST_OUT && out_acc) begin
				if (32'(och_q) + 1 < 32'(nc)) och_q <= och_q + CW'(1);
				else begin
					och_q <= '0;
					if (32'(ocol_q) + 1 < 32'(ow)) ocol_q <= ocol_q + DW'(1);
					else begin
						ocol_q <= '0;
						orow_q <= orow_q + DW'(1);
					end
				end
			end
		end
	end

	// address and datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			unique case (step_q)
				3'd0: prod_q <= (SW + DW)'(orow_q * rscale_q);
				3'd1: begin
					y0_q <= DW'(prod_q >> 16);
					fy_q <= prod_q[15:0];
					y1_q <= (32'(prod_q >> 16) + 1 < 32'(ih) - 1) ? DW'((prod_q >> 16) + 1)
						: DW'(ih - DW'(1));
					prod_q <= (SW + DW)'(ocol_q * cscale_q);
				end
				3'd2: begin
					x0_q <= DW'(prod_q >> 16);
					fx_q <= prod_q[15:0];
					x1_q <= (32'(prod_q >> 16) + 1 < 32'(iw) - 1) ? DW'((prod_q >> 16) + 1)
						: DW'(iw - DW'(1));
					rowoff_q[0] <= LW'(y0_q * iw);
					rowoff_q[1] <= LW'(y1_q * iw);
				end
				3'd3: begin
					rowoff_q[0] <= LW'(rowoff_q[0] * nc);
					rowoff_q[1] <= LW'(rowoff_q[1] * nc);
				end
				default: ;
			endcase
			acc_q <= '0;
		end
		// tap pipeline: address issued, then ram data and weight registered, then weighted term registered, then accumulated
		if (state_q == ST_TAP) begin
			oob_s1 <= (32'(tap_addr) >= STORE_DEPTH) || step_q[2];
			wt_q <= wy * wx;
			if (step_q >= 3'd1 && step_q <= 3'd4)
				term_q <= oob_s1 ? '0 : 51'(rd_data_q) * $signed({1'b0, wt_q});
			if (step_q >= 3'd2) acc_q <= acc_q + 52'(term_q);
		end
		// all four terms are in the accumulator by now
		if (state_q == ST_ROUND) begin
			logic signed [51:0] t;
			t = (acc_q + (52'sd1 <<< 31)) >>> 32;
			if (t > 52'sd32767) val_q <= 16'sd32767;
			else if (t < -52'sd32768) val_q <= -16'sd32768;
			else val_q <= t[15:0];
			last_q <= last_now;
		end
	end

	property p_stall_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> in_stall;
	endproperty
	a_stall_busy: assert property (p_stall_busy) else $error("accepted while busy");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n) (out_valid && out_stall) |=> $stable(value);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

	property p_load_bound;
		@(posedge clk) disable iff (!arst_n) 32'(load_pos_q) <= STORE_DEPTH;
	endproperty
	a_load_bound: assert property (p_load_bound) else $error("load position overflow");
endmodule
